>>> rtl/alc_pkg.sv
// Shared types and codes for the analog limit alarm channel.
package alc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_RAW_WINDOW   = 3'd0,
    CFG_ENG_BASE     = 3'd1,
    CFG_ENG_SLOPE    = 3'd2,
    CFG_HIGH_LIMIT   = 3'd3,
    CFG_LOW_LIMIT    = 3'd4,
    CFG_HIGH_DELAYS  = 3'd5,
    CFG_LOW_DELAYS   = 3'd6,
    CFG_ALARM_ENABLE = 3'd7
  } cfg_idx_t;

  // Event codes of a result
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_HIGH     = 2'd1,
    EV_LOW      = 2'd2,
    EV_IN_RANGE = 2'd3
  } event_t;

  // Scaled value reported for a sample outside the raw window (-1.0)
  localparam logic signed [31:0] OUT_OF_WINDOW_VALUE = 32'shFFFF0000;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [15:0]        raw_zero;
    logic [15:0]        raw_full;
    logic signed [31:0] eng_base;
    logic signed [31:0] eng_slope;
    logic signed [31:0] high_limit;
    logic signed [31:0] low_limit;
    logic [15:0]        high_on_dly;
    logic [15:0]        high_off_dly;
    logic [15:0]        low_on_dly;
    logic [15:0]        low_off_dly;
    logic               high_en;
    logic               low_en;
  } cfg_t;

  // Classified sample handed from the front end to the alarm logic
  typedef struct packed {
    logic               in_window;
    logic signed [31:0] eng_value;
    logic               over_high;
    logic               under_low;
    logic [31:0]        now_seconds;
  } item_t;

endpackage

>>> rtl/alc_if.sv
// Sample and result channel interfaces.
interface alc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_sample;
  logic [31:0] now_seconds;

  modport source (output valid, output raw_sample, output now_seconds, input ready);
  modport sink   (input valid, input raw_sample, input now_seconds, output ready);
endinterface

interface alc_out_if;
  logic               valid;
  logic               ready;
  logic               in_window;
  logic signed [31:0] eng_value;
  logic               alarm_high;
  logic               alarm_low;
  logic [1:0]         event_res;

  modport source (output valid, output in_window, output eng_value, output alarm_high,
                  output alarm_low, output event_res, input ready);
  modport sink   (input valid, input in_window, input eng_value, input alarm_high,
                  input alarm_low, input event_res, output ready);
endinterface

>>> rtl/alc_front.sv
// Front end: window check, linear scaling, saturation and limit compare.
module alc_front (
  input  logic                clk,
  input  logic                rst,
  input  alc_pkg::cfg_t       cfg,
  alc_in_if.sink              samples,
  input  logic                q_full,
  output logic                q_push,
  output alc_pkg::item_t      q_item
);

  // Stage 1: window check and offset from raw zero
  logic        s1_valid;
  logic        s1_win;
  logic [15:0] s1_diff;
  logic [31:0] s1_now;

  // Stage 2: product of slope and offset
  logic               s2_valid;
  logic               s2_win;
  logic signed [48:0] s2_prod;
  logic [31:0]        s2_now;

  logic s1_adv;
  logic s2_adv;

  logic signed [49:0] sum;
  logic signed [31:0] val;
  logic               sat_hi;
  logic               sat_lo;

  // Advance each stage when it is empty or its contents move on
  assign q_push        = s2_valid && !q_full;
  assign s2_adv        = !s2_valid || q_push;
  assign s1_adv        = !s1_valid || s2_adv;
  assign samples.ready = s1_adv;

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= samples.valid;
    end
    if (s1_adv) begin
      s1_win  <= (samples.raw_sample >= cfg.raw_zero) &&
                 (samples.raw_sample <= cfg.raw_full);
      s1_diff <= samples.raw_sample - cfg.raw_zero;
      s1_now  <= samples.now_seconds;
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
    if (s2_adv) begin
      s2_win  <= s1_win;
      s2_prod <= cfg.eng_slope * $signed({1'b0, s1_diff});
      s2_now  <= s1_now;
    end
  end

  // Add the base, saturate to 32 bits, compare with the limits; out of window give -1.0, no compare
  always_comb begin
    sum    = 50'(s2_prod) + 50'(cfg.eng_base);
    sat_hi = !sum[49] && (|sum[48:31]);
    sat_lo = sum[49] && !(&sum[48:31]);
    if (sat_hi) begin
      val = 32'sh7FFFFFFF;
    end else if (sat_lo) begin
      val = 32'sh80000000;
    end else begin
      val = sum[31:0];
    end
    q_item.in_window   = s2_win;
    q_item.now_seconds = s2_now;
    if (s2_win) begin
      q_item.eng_value = val;
      q_item.over_high = val > cfg.high_limit;
      q_item.under_low = val < cfg.low_limit;
    end else begin
      q_item.eng_value = alc_pkg::OUT_OF_WINDOW_VALUE;
      q_item.over_high = 1'b0;
      q_item.under_low = 1'b0;
    end
  end

endmodule

>>> rtl/alc_queue.sv
// Short queue of classified samples between the front end and the alarm logic.
module alc_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  alc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output alc_pkg::item_t head_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  alc_pkg::item_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign full       = count == CntW'(DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Write the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/alc_back.sv
// Alarm logic: assert and hold-off delays, alarm state and result register.
module alc_back (
  input  logic           clk,
  input  logic           rst,
  input  alc_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  alc_pkg::item_t head_item,
  output logic           pop,
  alc_out_if.source      results
);

  logic        high_active;
  logic        low_active;
  logic [31:0] high_on_start;
  logic [31:0] high_off_start;
  logic [31:0] low_on_start;
  logic [31:0] low_off_start;

  logic        high_active_next;
  logic        low_active_next;
  logic [31:0] high_on_start_next;
  logic [31:0] high_off_start_next;
  logic [31:0] low_on_start_next;
  logic [31:0] low_off_start_next;
  alc_pkg::event_t ev;

  logic        ih;
  logic        il;
  logic        vh;
  logic        vl;
  logic [31:0] now;

  // Signed difference between now and a start time
  function automatic logic signed [33:0] elapsed(input logic [31:0] t_now,
                                                 input logic [31:0] t_start);
    elapsed = $signed({2'b00, t_now}) - $signed({2'b00, t_start});
  endfunction

  // Decide whether one alarm is active after this sample
  function automatic logic decide(input logic en, input logic over, input logic active,
                                  input logic [31:0] t_now, input logic [31:0] on_start,
                                  input logic [31:0] off_start, input logic [15:0] on_dly,
                                  input logic [15:0] off_dly);
    logic assert_ok;
    logic hold;
    assert_ok = over && ((on_dly == '0) ||
                ((on_start != '0) &&
                 (elapsed(t_now, on_start) >= $signed({18'd0, on_dly}))));
    hold = !over && active && (off_dly != '0) &&
           ((off_start == '0) ||
            (elapsed(t_now, off_start) < $signed({18'd0, off_dly})));
    decide = en && (assert_ok || hold);
  endfunction

  // Take a beat when the result register is free or being drained
  assign pop = head_valid && (!results.valid || results.ready);

  assign vh  = head_item.over_high;
  assign vl  = head_item.under_low;
  assign now = head_item.now_seconds;
  assign ih  = decide(cfg.high_en, vh, high_active, now, high_on_start, high_off_start,
                      cfg.high_on_dly, cfg.high_off_dly);
  assign il  = decide(cfg.low_en, vl, low_active, now, low_on_start, low_off_start,
                      cfg.low_on_dly, cfg.low_off_dly);

  // Next alarm state and event
  always_comb begin
    high_active_next    = high_active;
    low_active_next     = low_active;
    high_on_start_next  = high_on_start;
    high_off_start_next = high_off_start;
    low_on_start_next   = low_on_start;
    low_off_start_next  = low_off_start;
    ev                  = alc_pkg::EV_NONE;
    if (head_item.in_window) begin
      if (ih) begin
        if (!high_active) begin
          high_active_next = 1'b1;
          low_active_next  = 1'b0;
          ev               = alc_pkg::EV_HIGH;
        end
        low_off_start_next = '0;
        if (vh) begin
          high_off_start_next = '0;
          low_on_start_next   = '0;
        end else begin
          if (high_off_start == '0) begin
            high_off_start_next = now;
          end
          low_on_start_next = vl ? now : '0;
        end
      end else if (il) begin
        if (!low_active) begin
          low_active_next  = 1'b1;
          high_active_next = 1'b0;
          ev               = alc_pkg::EV_LOW;
        end
        high_off_start_next = '0;
        if (vl) begin
          low_off_start_next = '0;
          high_on_start_next = '0;
        end else begin
          if (low_off_start == '0) begin
            low_off_start_next = now;
          end
          high_on_start_next = vh ? now : '0;
        end
      end else begin
        if (high_active || low_active) begin
          high_active_next = 1'b0;
          low_active_next  = 1'b0;
          if (!vh && !vl) begin
            ev = alc_pkg::EV_IN_RANGE;
          end
        end
        if (vh) begin
          low_on_start_next = '0;
          if (high_on_start == '0) begin
            high_on_start_next = now;
          end
        end else if (vl) begin
          high_on_start_next = '0;
          if (low_on_start == '0) begin
            low_on_start_next = now;
          end
        end else begin
          high_on_start_next = '0;
          low_on_start_next  = '0;
        end
      end
    end
  end

  // Hold the alarm state, update it on each beat taken
  always_ff @(posedge clk) begin
    if (rst) begin
      high_active    <= 1'b0;
      low_active     <= 1'b0;
      high_on_start  <= '0;
      high_off_start <= '0;
      low_on_start   <= '0;
      low_off_start  <= '0;
    end else if (pop) begin
      high_active    <= high_active_next;
      low_active     <= low_active_next;
      high_on_start  <= high_on_start_next;
      high_off_start <= high_off_start_next;
      low_on_start   <= low_on_start_next;
      low_off_start  <= low_off_start_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (pop) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (pop) begin
      results.in_window  <= head_item.in_window;
      results.eng_value  <= head_item.eng_value;
      results.alarm_high <= high_active_next;
      results.alarm_low  <= low_active_next;
      results.event_res  <= ev;
    end
  end

endmodule

>>> rtl/analog_limit_alarm_with_delays.sv
// A sample passes the stage 1 and 2 registers, the queue and the result register.
// One sample per cycle while results are taken: the front end (window check, 32x17
// multiply, add, saturate and compare over two stages) and the alarm logic each
// keep that rate. A queue of QUEUE_DEPTH beats absorbs result stalls until it fills.
// Reset clears the pipeline, queue, alarm state and result register and loads the
// configuration reset values; the block accepts samples in the cycle after reset.
module analog_limit_alarm_with_delays #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  alc_in_if.sink      samples,
  alc_out_if.source   results
);

  alc_pkg::cfg_t  cfg;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  alc_pkg::item_t q_in_item;
  alc_pkg::item_t q_head_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_zero     <= 16'h0000;
      cfg.raw_full     <= 16'hFFFF;
      cfg.eng_base     <= 32'sh0;
      cfg.eng_slope    <= 32'sh00010000;
      cfg.high_limit   <= 32'sh7FFFFFFF;
      cfg.low_limit    <= 32'sh80000000;
      cfg.high_on_dly  <= '0;
      cfg.high_off_dly <= '0;
      cfg.low_on_dly   <= '0;
      cfg.low_off_dly  <= '0;
      cfg.high_en      <= 1'b0;
      cfg.low_en       <= 1'b0;
    end else if (cfg_we) begin
      unique case (alc_pkg::cfg_idx_t'(cfg_index))
        alc_pkg::CFG_RAW_WINDOW: begin
          cfg.raw_zero <= cfg_data[15:0];
          cfg.raw_full <= cfg_data[31:16];
        end
        alc_pkg::CFG_ENG_BASE:    cfg.eng_base   <= cfg_data;
        alc_pkg::CFG_ENG_SLOPE:   cfg.eng_slope  <= cfg_data;
        alc_pkg::CFG_HIGH_LIMIT:  cfg.high_limit <= cfg_data;
        alc_pkg::CFG_LOW_LIMIT:   cfg.low_limit  <= cfg_data;
        alc_pkg::CFG_HIGH_DELAYS: begin
          cfg.high_on_dly  <= cfg_data[15:0];
          cfg.high_off_dly <= cfg_data[31:16];
        end
        alc_pkg::CFG_LOW_DELAYS: begin
          cfg.low_on_dly  <= cfg_data[15:0];
          cfg.low_off_dly <= cfg_data[31:16];
        end
        alc_pkg::CFG_ALARM_ENABLE: begin
          cfg.high_en <= cfg_data[0];
          cfg.low_en  <= cfg_data[1];
        end
        default: ;
      endcase
    end
  end

  alc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  alc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head_item)
  );

  alc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_valid),
    .head_item  (q_head_item),
    .pop        (q_pop),
    .results    (results)
  );

`ifndef NO_ASSERTIONS
  // An out-of-window beat reports -1.0 and no event
  a_out_of_window: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.in_window |->
      results.event_res == alc_pkg::EV_NONE &&
      results.eng_value == alc_pkg::OUT_OF_WINDOW_VALUE)
    else $error("out-of-window result carries a value or event");

  // High and low alarms are never up together
  a_alarms_exclusive: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.alarm_high && results.alarm_low))
    else $error("high and low alarm both active");

  // An entered-high event comes with the high alarm flag
  a_event_flags: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.event_res == alc_pkg::EV_HIGH) |-> results.alarm_high)
    else $error("entered-high event without high alarm");

  // Back in range leaves both alarms down
  a_in_range_clear: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.event_res == alc_pkg::EV_IN_RANGE) |->
      !results.alarm_high && !results.alarm_low)
    else $error("back-in-range event with an alarm still active");
`endif

endmodule

>>> tb/alc_tb_pkg.sv
// Alarm channel predictor and result scoreboard for the testbench.
package alc_tb_pkg;
  import alc_pkg::*;

  localparam longint ENG_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ENG_MIN = -64'sh0000_0000_8000_0000;

  // One result beat as the block should present it
  typedef struct packed {
    logic               in_window;
    logic signed [31:0] eng_value;
    logic               alarm_high;
    logic               alarm_low;
    event_t             ev;
  } alarm_result_t;

  // Linear 16.16 scaling of an in-window reading, saturated to 32 bits
  function automatic longint scale_reading(logic [15:0] raw, logic [31:0] window,
                                           logic signed [31:0] base,
                                           logic signed [31:0] slope);
    logic [15:0] span;
    longint v;
    span = raw - window[15:0];
    v = longint'(base) + longint'(slope) * longint'({1'b0, span});
    if (v > ENG_MAX) v = ENG_MAX;
    if (v < ENG_MIN) v = ENG_MIN;
    return v;
  endfunction

  class alarm_tracker;
    logic [31:0]        raw_window;
    logic signed [31:0] eng_base;
    logic signed [31:0] eng_slope;
    logic signed [31:0] high_limit;
    logic signed [31:0] low_limit;
    logic [31:0]        high_delays;
    logic [31:0]        low_delays;
    logic [1:0]         alarm_enable;

    // Alarm flags and the seconds at which each delay began (0: not running)
    bit          high_on;
    bit          low_on;
    logic [31:0] high_rise_t;
    logic [31:0] high_fall_t;
    logic [31:0] low_rise_t;
    logic [31:0] low_fall_t;

    alarm_result_t due_results[$];
    int errors;

    function new();
      errors = 0;
      raw_window   = 32'hFFFF_0000;
      eng_base     = 32'sd0;
      eng_slope    = 32'sh0001_0000;
      high_limit   = 32'sh7FFF_FFFF;
      low_limit    = 32'sh8000_0000;
      high_delays  = 32'd0;
      low_delays   = 32'd0;
      alarm_enable = 2'd0;
      high_on      = 1'b0;
      low_on       = 1'b0;
      high_rise_t  = 32'd0;
      high_fall_t  = 32'd0;
      low_rise_t   = 32'd0;
      low_fall_t   = 32'd0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_RAW_WINDOW:   raw_window   = data;
        CFG_ENG_BASE:     eng_base     = data;
        CFG_ENG_SLOPE:    eng_slope    = data;
        CFG_HIGH_LIMIT:   high_limit   = data;
        CFG_LOW_LIMIT:    low_limit    = data;
        CFG_HIGH_DELAYS:  high_delays  = data;
        CFG_LOW_DELAYS:   low_delays   = data;
        CFG_ALARM_ENABLE: alarm_enable = data[1:0];
        default: ;
      endcase
    endfunction

    // Whether one alarm should be up: assert delay met, or hold-off still running.
    // Ages are signed, so a clock that steps back never meets a delay.
    function bit alarm_wanted(bit en, bit over, bit active, logic [31:0] now,
                              logic [31:0] rise_t, logic [31:0] fall_t,
                              logic [15:0] on_dly, logic [15:0] off_dly);
      longint rise_age, fall_age;
      bit rise_ok, hold;
      rise_age = longint'({32'd0, now}) - longint'({32'd0, rise_t});
      fall_age = longint'({32'd0, now}) - longint'({32'd0, fall_t});
      rise_ok = over && (on_dly == 0 ||
                (rise_t != 0 && rise_age >= longint'({48'd0, on_dly})));
      hold = !over && active && off_dly != 0 &&
             (fall_t == 0 || fall_age < longint'({48'd0, off_dly}));
      return en && (rise_ok || hold);
    endfunction

    // Advance the alarm state by one accepted sample and queue its result
    function void note_sample(logic [15:0] raw, logic [31:0] now);
      longint v;
      bit vh, vl, ih, il;
      event_t ev;
      ev = EV_NONE;

      // Outside the raw window: report -1.0 and leave the state alone
      if (raw > raw_window[31:16] || raw < raw_window[15:0]) begin
        due_results.push_back('{1'b0, OUT_OF_WINDOW_VALUE, high_on, low_on, EV_NONE});
        return;
      end

      v  = scale_reading(raw, raw_window, eng_base, eng_slope);
      vh = v > longint'(high_limit);
      vl = v < longint'(low_limit);
      ih = alarm_wanted(alarm_enable[0], vh, high_on, now, high_rise_t, high_fall_t,
                        high_delays[15:0], high_delays[31:16]);
      il = alarm_wanted(alarm_enable[1], vl, low_on, now, low_rise_t, low_fall_t,
                        low_delays[15:0], low_delays[31:16]);

      if (ih) begin
        if (!high_on) begin
          high_on = 1'b1;
          low_on  = 1'b0;
          ev      = EV_HIGH;
        end
        low_fall_t = 32'd0;
        if (vh) begin
          high_fall_t = 32'd0;
          low_rise_t  = 32'd0;
        end else begin
          if (high_fall_t == 0) high_fall_t = now;
          low_rise_t = vl ? now : 32'd0;
        end
      end else if (il) begin
        if (!low_on) begin
          low_on  = 1'b1;
          high_on = 1'b0;
          ev      = EV_LOW;
        end
        high_fall_t = 32'd0;
        if (vl) begin
          low_fall_t  = 32'd0;
          high_rise_t = 32'd0;
        end else begin
          if (low_fall_t == 0) low_fall_t = now;
          high_rise_t = vh ? now : 32'd0;
        end
      end else begin
        // Drop any alarm; only a value between the limits counts as back in range
        if (high_on || low_on) begin
          high_on = 1'b0;
          low_on  = 1'b0;
          if (!vh && !vl) ev = EV_IN_RANGE;
        end
        if (vh) begin
          low_rise_t = 32'd0;
          if (high_rise_t == 0) high_rise_t = now;
        end else if (vl) begin
          high_rise_t = 32'd0;
          if (low_rise_t == 0) low_rise_t = now;
        end else begin
          high_rise_t = 32'd0;
          low_rise_t  = 32'd0;
        end
      end

      due_results.push_back('{1'b1, v[31:0], high_on, low_on, ev});
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat with the oldest outstanding prediction
    function void check_result(alarm_result_t got);
      alarm_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with no sample outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("in_window", want.in_window, got.in_window);
      check_field("eng_value", want.eng_value, got.eng_value);
      check_field("alarm_high", want.alarm_high, got.alarm_high);
      check_field("alarm_low", want.alarm_low, got.alarm_low);
      check_field("event_res", want.ev, got.ev);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// Top-level testbench for the analog limit alarm channel.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import alc_pkg::*;
  import alc_tb_pkg::*;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 120;
  localparam int LATENCY      = 4;
  localparam int STALL_CYCLES = 80;
  // A correct run is never quiet for much more than a hold-off plus a drain and a
  // register update; allow many times that.
  localparam int QUIET_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  alc_in_if  samples ();
  alc_out_if results ();

  analog_limit_alarm_with_delays i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .results   (results)
  );

  alarm_tracker tracker = new();

  logic [31:0] reg_plan [8];
  bit          idle_on      = 1'b0;
  int          stall_req    = 0;
  int          stall_ack    = 0;
  int          stall_left   = 0;
  int          quiet_cycles = 0;

  always #10 clk = ~clk;

  // Result side: long hold-off on request, otherwise occasional idle cycles
  always @(negedge clk) begin
    if (stall_req != stall_ack) begin
      stall_ack     <= stall_req;
      stall_left    <= STALL_CYCLES;
      results.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      results.ready <= 1'b0;
    end else begin
      results.ready <= !(idle_on && $urandom_range(0, 99) < 6);
    end
  end

  // Check every result beat
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      tracker.check_result(alarm_result_t'{results.in_window, results.eng_value,
                                           results.alarm_high, results.alarm_low,
                                           event_t'(results.event_res)});
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample beat and hold it until accepted
  task automatic send_sample(input logic [15:0] raw, input logic [31:0] now);
    while (idle_on && $urandom_range(0, 99) < 6) begin
      @(negedge clk);
      samples.valid <= 1'b0;
    end
    @(negedge clk);
    samples.valid       <= 1'b1;
    samples.raw_sample  <= raw;
    samples.now_seconds <= now;
    do @(posedge clk); while (!samples.ready);
    tracker.note_sample(raw, now);
  endtask

  // Stop sending and wait until every outstanding result has come back
  task automatic settle();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Load all eight registers from the plan, one per cycle
  task automatic write_reg_set();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= reg_plan[i];
      tracker.write_reg(cfg_idx_t'(i), reg_plan[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] level_in_window(logic [31:0] window);
    if (window[15:0] <= window[31:16]) return 16'($urandom_range(window[31:16], window[15:0]));
    return 16'($urandom);
  endfunction

  // Mostly short delays so alarms really fire; now and then a long one
  function automatic logic [15:0] delay_choice();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4));
  endfunction

  // Step the seconds counter: mostly forward, sometimes back, sometimes far
  function automatic logic [31:0] next_wall(logic [31:0] t);
    int unsigned r;
    logic [31:0] n;
    r = $urandom_range(0, 99);
    if (r < 70)      n = t + $urandom_range(0, 2);
    else if (r < 85) n = t + $urandom_range(3, 8);
    else if (r < 93) n = t - $urandom_range(1, 5);
    else if (r < 97) n = t + $urandom_range(9, 65535);
    else             n = $urandom;
    return (n == 0) ? 32'd1 : n;
  endfunction

  // Register settings for one random phase; limits sit on reachable values
  task automatic plan_phase(input int p);
    logic [15:0] lo, hi;
    longint va, vb;
    if (p == 3) begin
      reg_plan = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3};
    end else if (p == 7) begin
      reg_plan = '{32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'd0, 32'd0, 32'd0};
    end else begin
      lo = 16'($urandom_range(0, 50000));
      if ($urandom_range(0, 2) == 0) hi = lo + 16'($urandom_range(0, 64));
      else                           hi = 16'($urandom_range(lo, 65535));
      // Raw zero above raw full leaves the window empty
      if (p == 10) begin
        lo = 16'($urandom_range(1, 65535));
        hi = 16'($urandom_range(0, lo - 1));
      end
      reg_plan[CFG_RAW_WINDOW] = {hi, lo};
      reg_plan[CFG_ENG_BASE]   = $urandom_range(0, 1) ? $urandom : $signed($urandom) >>> 8;
      if ($urandom_range(0, 3) == 0) reg_plan[CFG_ENG_SLOPE] = $urandom;
      else reg_plan[CFG_ENG_SLOPE] = $urandom_range(0, 32'h30000) - 32'h18000;
      va = scale_reading(level_in_window(reg_plan[CFG_RAW_WINDOW]), reg_plan[CFG_RAW_WINDOW],
                         reg_plan[CFG_ENG_BASE], reg_plan[CFG_ENG_SLOPE]);
      vb = scale_reading(level_in_window(reg_plan[CFG_RAW_WINDOW]), reg_plan[CFG_RAW_WINDOW],
                         reg_plan[CFG_ENG_BASE], reg_plan[CFG_ENG_SLOPE]);
      // Now and then cross the limits so a value can be both high and low
      if ((va > vb) ^ ($urandom_range(0, 4) == 0)) begin
        reg_plan[CFG_HIGH_LIMIT] = va[31:0];
        reg_plan[CFG_LOW_LIMIT]  = vb[31:0];
      end else begin
        reg_plan[CFG_HIGH_LIMIT] = vb[31:0];
        reg_plan[CFG_LOW_LIMIT]  = va[31:0];
      end
      reg_plan[CFG_HIGH_DELAYS]  = {delay_choice(), delay_choice()};
      reg_plan[CFG_LOW_DELAYS]   = {delay_choice(), delay_choice()};
      reg_plan[CFG_ALARM_ENABLE] = $urandom_range(0, 1) ? 32'd3 : $urandom_range(0, 3);
    end
  endtask

  initial begin
    logic [15:0] raw;
    logic [15:0] raw_lvl;
    logic [31:0] wall_s;
    int unsigned r;

    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_RAW_WINDOW;
    cfg_data            = 32'd0;
    samples.valid       = 1'b0;
    samples.raw_sample  = 16'd0;
    samples.now_seconds = 32'd1;
    results.ready       = 1'b0;
    raw_lvl             = 16'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Reset settings: full window, unit scale, alarms off; field extremes
    send_sample(16'd0, 32'd1);
    send_sample(16'hFFFF, 32'hFFFF_FFFF);
    send_sample(16'h5555, 32'hAAAA_AAAA);
    settle();

    // Window 100..1000, value = (raw - 100) in 16.16, high above 400, low below 100
    reg_plan = '{{16'd1000, 16'd100}, 32'd0, 32'h0001_0000, 32'd400 << 16,
                 32'd100 << 16, {16'd3, 16'd2}, {16'd2, 16'd1}, 32'd3};
    write_reg_set();
    send_sample(16'd50, 32'd5);     // below raw zero
    send_sample(16'd1001, 32'd5);   // above raw full
    send_sample(16'd300, 32'd6);
    send_sample(16'd600, 32'd10);   // high condition starts the assert delay
    send_sample(16'd600, 32'd11);
    send_sample(16'd600, 32'd12);   // high asserts
    send_sample(16'd300, 32'd13);   // hold-off keeps it up
    send_sample(16'd300, 32'd15);
    send_sample(16'd300, 32'd16);   // hold-off over: back in range
    send_sample(16'd600, 32'd20);
    send_sample(16'd600, 32'd19);   // clock stepped back: delay not met
    send_sample(16'd600, 32'd22);
    send_sample(16'd150, 32'd23);   // low while high is held
    send_sample(16'd150, 32'd24);
    send_sample(16'd150, 32'd26);   // high released, low takes over
    send_sample(16'd300, 32'd27);
    send_sample(16'd300, 32'd40);
    settle();

    // Empty window: every reading is out of window
    reg_plan[CFG_RAW_WINDOW] = {16'd5, 16'd10};
    write_reg_set();
    send_sample(16'd7, 32'd41);
    send_sample(16'd10, 32'd42);

    // Random phases: readings dwell on a level so delays can elapse
    for (int p = 0; p < PHASES; p++) begin
      settle();
      plan_phase(p);
      write_reg_set();
      idle_on = (p != 5);
      case (p % 3)
        0:       wall_s = $urandom_range(1, 1000);
        1:       wall_s = $urandom | 32'd1;
        default: wall_s = 32'hFFFF_FFFF - $urandom_range(0, 300);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) stall_req++;
        if (p == 8 && n == 60) settle();
        r = $urandom_range(0, 99);
        if (r < 10) begin
          raw = 16'($urandom);
        end else begin
          if (r < 30) raw_lvl = level_in_window(reg_plan[CFG_RAW_WINDOW]);
          raw = raw_lvl;
        end
        wall_s = next_wall(wall_s);
        send_sample(raw, wall_s);
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> analog_limit_alarm_with_delays.f
rtl/alc_pkg.sv
rtl/alc_if.sv
rtl/alc_front.sv
rtl/alc_queue.sv
rtl/alc_back.sv
rtl/analog_limit_alarm_with_delays.sv
tb/alc_tb_pkg.sv
tb/tb_top.sv
